FILE: rtl/core/modular_exponentiation_top_defines.svh
// Assertion macros for the modular exponentiation block.
// Included by modular_exponentiation_top; depends on nothing else.
`ifndef MODULAR_EXPONENTIATION_TOP_DEFINES_SVH
`define MODULAR_EXPONENTIATION_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ME_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("modexp assertion failed");

// Next-cycle implication, disabled during reset.
`define ME_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("modexp assertion failed");

`endif

FILE: rtl/core/modexp_pkg.sv
// Package for the modular exponentiation block: widths, register indexes, state type.
// Used by modular_exponentiation_top; depends on nothing.
package modexp_pkg;

    localparam int DEF_WIDTH  = 32;
    localparam int FIELD_W    = 32;
    localparam int CFG_ADDR_W = 1;

    localparam logic [CFG_ADDR_W-1:0] REG_EXPONENT = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_MODULUS  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RED,
        S_MUL,
        S_SQR,
        S_DONE
    } t_state;

endpackage

FILE: rtl/core/modular_exponentiation_top.sv
// Channel      | Dir | Handshake               | Payload
// s_axis       | in  | s_axis_tvalid/tready    | tdata[31:0] = base
// m_axis       | out | m_axis_tvalid/tready    | tdata[31:0] = power_mod
// cfg          | in  | i_cfg_wen               | i_cfg_addr (0 exponent, 1 modulus), i_cfg_wdata
//
// One shared bit-serial modular multiplier does all work, one multiplier bit per cycle.
// A transaction reduces the base mod the modulus, then scans the exponent from its low bit:
// a multiply into the result for each set bit, a squaring before each higher bit.
// Exponent or modulus zero: straight to S_DONE; the result posts once the output is free.
// Synchronous active-low reset clears control state; config registers reset to 1.
// A result waits in the output register while the next transaction is accepted.
// Depends on modexp_pkg and modular_exponentiation_top_defines.svh.
`include "modular_exponentiation_top_defines.svh"

module modular_exponentiation_top #(
    parameter int WIDTH = modexp_pkg::DEF_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wen,
    input  logic [modexp_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [modexp_pkg::FIELD_W-1:0]      i_cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [modexp_pkg::FIELD_W-1:0]      s_axis_tdata,   // [31:0] base
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [modexp_pkg::FIELD_W-1:0]      m_axis_tdata    // [31:0] power_mod
);

    localparam int VW = (WIDTH < modexp_pkg::FIELD_W) ? WIDTH : modexp_pkg::FIELD_W;
    localparam int CW = $clog2(VW);

    modexp_pkg::t_state r_state, n_state;

    logic [VW-1:0] r_exponent, r_modulus;
    logic [VW-1:0] r_exp, n_exp;
    logic [VW-1:0] r_sh, n_sh;
    logic [VW-1:0] r_acc, n_acc;
    logic [VW-1:0] r_res, n_res;
    logic [VW-1:0] r_sq, n_sq;
    logic [VW-1:0] r_out, n_out;
    logic          r_ovld, n_ovld;
    logic [CW-1:0] r_cnt, n_cnt;

    logic          in_acc;
    logic          out_free;
    logic          last;
    logic [VW-1:0] op_a;
    logic [VW-1:0] addend;
    logic [VW+1:0] t_sum, t_m1, t_m2;
    logic [VW-1:0] acc_nx;

    assign s_axis_tready = (r_state == modexp_pkg::S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_ovld || m_axis_tready;
    assign last          = (r_cnt == '0);
    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = modexp_pkg::FIELD_W'(r_out);

    // acc' = (2*acc + addend) mod m, addend <= m so the sum stays below 3m
    assign op_a   = (r_state == modexp_pkg::S_MUL) ? r_res : r_sq;
    assign addend = (r_state == modexp_pkg::S_RED) ? VW'(r_sh[VW-1]) :
                    (r_sh[VW-1] ? op_a : '0);
    assign t_sum  = {1'b0, r_acc, 1'b0} + {2'b00, addend};
    assign t_m1   = {2'b00, r_modulus};
    assign t_m2   = {1'b0, r_modulus, 1'b0};

    always_comb begin
        if (t_sum >= t_m2) begin
            acc_nx = VW'(t_sum - t_m2);
        end else if (t_sum >= t_m1) begin
            acc_nx = VW'(t_sum - t_m1);
        end else begin
            acc_nx = t_sum[VW-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            modexp_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (r_exponent == '0 || r_modulus == '0) begin
                        n_state = modexp_pkg::S_DONE;
                    end else begin
                        n_state = modexp_pkg::S_RED;
                    end
                end
            end
            modexp_pkg::S_RED: begin
                if (last) begin
                    n_state = r_exp[0] ? modexp_pkg::S_MUL : modexp_pkg::S_SQR;
                end
            end
            modexp_pkg::S_MUL: begin
                if (last) begin
                    n_state = (r_exp[VW-1:1] == '0) ? modexp_pkg::S_DONE : modexp_pkg::S_SQR;
                end
            end
            modexp_pkg::S_SQR: begin
                if (last) begin
                    n_state = r_exp[1] ? modexp_pkg::S_MUL : modexp_pkg::S_SQR;
                end
            end
            modexp_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = modexp_pkg::S_IDLE;
                end
            end
            default: n_state = modexp_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_exp  = r_exp;
        n_sh   = r_sh;
        n_acc  = r_acc;
        n_res  = r_res;
        n_sq   = r_sq;
        n_cnt  = r_cnt;
        n_out  = r_out;
        n_ovld = r_ovld;
        if (r_ovld && m_axis_tready) begin
            n_ovld = 1'b0;
        end
        unique case (r_state)
            modexp_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_sh  = s_axis_tdata[VW-1:0];
                    n_exp = r_exponent;
                    n_acc = '0;
                    n_cnt = CW'(VW - 1);
                    if (r_exponent == '0) begin
                        n_res = VW'(1);
                    end else if (r_modulus <= VW'(1)) begin
                        n_res = '0;
                    end else begin
                        n_res = VW'(1);
                    end
                end
            end
            modexp_pkg::S_RED, modexp_pkg::S_MUL, modexp_pkg::S_SQR: begin
                n_acc = acc_nx;
                n_sh  = r_sh << 1;
                n_cnt = r_cnt - CW'(1);
                if (last) begin
                    n_acc = '0;
                    n_cnt = CW'(VW - 1);
                    if (r_state == modexp_pkg::S_MUL) begin
                        n_res = acc_nx;
                        n_sh  = r_sq;
                    end else begin
                        n_sq = acc_nx;
                        n_sh = acc_nx;
                        if (r_state == modexp_pkg::S_SQR) begin
                            n_exp = r_exp >> 1;
                        end
                    end
                end
            end
            modexp_pkg::S_DONE: begin
                if (out_free) begin
                    n_out  = r_res;
                    n_ovld = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= modexp_pkg::S_IDLE;
            r_ovld     <= 1'b0;
            r_exponent <= VW'(1);
            r_modulus  <= VW'(1);
        end else begin
            r_state <= n_state;
            r_ovld  <= n_ovld;
            if (i_cfg_wen) begin
                unique case (i_cfg_addr)
                    modexp_pkg::REG_EXPONENT: r_exponent <= i_cfg_wdata[VW-1:0];
                    modexp_pkg::REG_MODULUS:  r_modulus  <= i_cfg_wdata[VW-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_exp <= n_exp;
        r_sh  <= n_sh;
        r_acc <= n_acc;
        r_res <= n_res;
        r_sq  <= n_sq;
        r_cnt <= n_cnt;
        r_out <= n_out;
    end

    `ME_ASSERT_NOW(a_acc_reduced, i_clk, i_rst_n,
        (r_state == modexp_pkg::S_RED || r_state == modexp_pkg::S_MUL ||
         r_state == modexp_pkg::S_SQR),
        (r_acc < r_modulus))
    `ME_ASSERT_NOW(a_operands_reduced, i_clk, i_rst_n,
        (r_state == modexp_pkg::S_MUL || r_state == modexp_pkg::S_SQR),
        (r_res < r_modulus && r_sq < r_modulus))
    `ME_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, in_acc,
        (r_state != modexp_pkg::S_IDLE))
    `ME_ASSERT_NEXT(a_done_posts, i_clk, i_rst_n,
        (r_state == modexp_pkg::S_DONE && out_free),
        (r_ovld && r_state == modexp_pkg::S_IDLE))

endmodule

FILE: bench/tb_modular_exponentiation_top.sv
// Self-checking bench for modular_exponentiation_top: base in, base^exponent mod modulus out.
// Drives random gaps and stalls and checks each result against its own predictor.
// Depends on modexp_pkg and the block's RTL.
module tb_modular_exponentiation_top;

    localparam int CYCLE_LIMIT = 3_000_000;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_cfg_wen = 1'b0;
    logic [modexp_pkg::CFG_ADDR_W-1:0] i_cfg_addr = modexp_pkg::REG_EXPONENT;
    logic [modexp_pkg::FIELD_W-1:0]    i_cfg_wdata = '0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [modexp_pkg::FIELD_W-1:0]    s_axis_tdata = '0;    // [31:0] base
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [modexp_pkg::FIELD_W-1:0]    m_axis_tdata;         // [31:0] power_mod

    logic [31:0] cur_exponent = 32'd1;
    logic [31:0] cur_modulus = 32'd1;
    logic [31:0] base_queue[$];
    logic [31:0] power_mod_due[$];
    int          send_idle_pct = 20;
    int          recv_idle_pct = 20;
    bit          quiet = 1'b0;
    int          send_gap = 0;
    int          recv_gap = 0;
    int          errors = 0;
    int          cycle_count = 0;

    modular_exponentiation_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [31:0] power_mod_of(input logic [31:0] base);
        logic [63:0] acc;
        logic [63:0] sq;
        logic [63:0] m;
        logic [31:0] e;
        if (cur_exponent == 32'd0) return 32'd1;
        if (cur_modulus == 32'd0) return 32'd0;
        m   = {32'd0, cur_modulus};
        sq  = {32'd0, base} % m;
        acc = 64'd1 % m;
        e   = cur_exponent;
        while (e != 32'd0) begin
            if (e[0]) acc = (acc * sq) % m;
            sq = (sq * sq) % m;
            e  = e >> 1;
        end
        return acc[31:0];
    endfunction

    always @(posedge i_clk) begin : driver
        logic                           nxt_valid;
        logic [modexp_pkg::FIELD_W-1:0] nxt_data;
        nxt_valid = s_axis_tvalid;
        nxt_data  = s_axis_tdata;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
            send_gap  = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                power_mod_due.push_back(power_mod_of(s_axis_tdata));
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (!quiet && $urandom_range(0, 99) < send_idle_pct) begin
                    send_gap = $urandom_range(0, 14);
                end else if (base_queue.size() != 0) begin
                    nxt_valid = 1'b1;
                    nxt_data  = base_queue.pop_front();
                end
            end
        end
        s_axis_tvalid <= nxt_valid;
        s_axis_tdata  <= nxt_data;
    end

    always @(posedge i_clk) begin : monitor
        logic [31:0] want;
        logic        nxt_ready;
        nxt_ready = 1'b0;
        if (!i_rst_n) begin
            recv_gap = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (power_mod_due.size() == 0) begin
                    $error("power_mod: no transaction expected, actual %h", m_axis_tdata);
                    errors++;
                end else begin
                    want = power_mod_due.pop_front();
                    if (m_axis_tdata !== want) begin
                        $error("power_mod mismatch: expected %h, actual %h", want, m_axis_tdata);
                        errors++;
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
            end else if (!quiet && $urandom_range(0, 99) < recv_idle_pct) begin
                recv_gap = $urandom_range(0, 14);
            end else begin
                nxt_ready = 1'b1;
            end
        end
        m_axis_tready <= nxt_ready;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic wait_drain();
        @(negedge i_clk);
        while (base_queue.size() != 0 || power_mod_due.size() != 0 || s_axis_tvalid)
            @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [modexp_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [31:0] value);
        @(posedge i_clk);
        i_cfg_wen   <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        if (idx == modexp_pkg::REG_EXPONENT) cur_exponent = value;
        else cur_modulus = value;
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
    endtask

    task automatic set_config(input logic [31:0] e, input logic [31:0] m);
        wait_drain();
        write_reg(modexp_pkg::REG_EXPONENT, e);
        write_reg(modexp_pkg::REG_MODULUS, m);
    endtask

    initial begin
        int          p;
        int          k;
        logic [31:0] e;
        logic [31:0] m;
        logic [31:0] b;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset values: exponent 1, modulus 1
        base_queue.push_back(32'h0000_0000);
        base_queue.push_back(32'hFFFF_FFFF);

        // exponent zero gives 1 even with modulus 1
        set_config(32'd0, 32'd1);
        base_queue.push_back(32'h0000_0000);
        base_queue.push_back(32'hFFFF_FFFF);

        set_config(32'd0, 32'hFFFF_FFFF);
        base_queue.push_back(32'h1234_5678);

        set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        base_queue.push_back(32'h0000_0000);
        base_queue.push_back(32'h0000_0001);
        base_queue.push_back(32'hFFFF_FFFE);
        base_queue.push_back(32'hFFFF_FFFF);
        base_queue.push_back(32'h8000_0000);

        set_config(32'd65537, 32'hFFFF_FFFB);
        base_queue.push_back(32'hFFFF_FFFA);
        base_queue.push_back(32'hFFFF_FFFB);
        base_queue.push_back(32'hFFFF_FFFC);
        base_queue.push_back(32'h0000_0002);

        // modulus one with nonzero exponent gives 0
        set_config(32'd5, 32'd1);
        base_queue.push_back(32'h0000_0007);

        set_config(32'd2, 32'd2);
        base_queue.push_back(32'h0000_0003);
        base_queue.push_back(32'h0000_0004);

        set_config(32'h8000_0000, 32'h8000_0001);
        base_queue.push_back(32'h7FFF_FFFF);
        base_queue.push_back(32'h5555_5555);

        for (p = 0; p < 10; p++) begin
            case ($urandom_range(0, 5))
                0: e = $urandom_range(2, 16);
                1: e = $urandom();
                2: e = 32'hFFFF_FFFF;
                3: e = 32'd1 << $urandom_range(0, 31);
                4: e = $urandom_range(0, 3);
                default: e = $urandom() >> $urandom_range(0, 28);
            endcase
            case ($urandom_range(0, 5))
                0: m = $urandom_range(1, 255);
                1: m = $urandom() | 32'h8000_0000;
                2: m = 32'hFFFF_FFFF;
                3: m = $urandom() >> $urandom_range(0, 31);
                4: m = 32'd1 << $urandom_range(0, 31);
                default: m = $urandom() | 32'd1;
            endcase
            if (m == 32'd0) m = 32'd1;
            set_config(e, m);
            case ($urandom_range(0, 3))
                0: send_idle_pct = 0;
                1: send_idle_pct = 10;
                2: send_idle_pct = 30;
                default: send_idle_pct = 60;
            endcase
            case ($urandom_range(0, 3))
                0: recv_idle_pct = 0;
                1: recv_idle_pct = 10;
                2: recv_idle_pct = 30;
                default: recv_idle_pct = 60;
            endcase
            if (p == 9) quiet = 1'b1;
            for (k = 0; k < 25; k++) begin
                case ($urandom_range(0, 5))
                    3: b = $urandom_range(0, 3);
                    4: b = m - 32'd1 + $urandom_range(0, 2);
                    5: b = 32'hFFFF_FFFF - $urandom_range(0, 3);
                    default: b = $urandom();
                endcase
                base_queue.push_back(b);
            end
        end

        wait_drain();
        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
